// ===== hdl/descending_sorted_list_table_top_assert.svh =====
// Assertion macros used by the sorted table engine (dslt_engine).
`ifndef DESCENDING_SORTED_LIST_TABLE_TOP_ASSERT_SVH
`define DESCENDING_SORTED_LIST_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSLT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated in sorted table");

// The consequent must hold in the cycle after the antecedent.
`define DSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated in sorted table");

`endif

// ===== hdl/dslt_pkg.sv =====
package dslt_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] match_count;
        logic [4:0] entry_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

// ===== hdl/dslt_engine.sv =====
module dslt_engine #(
    parameter int CAPACITY = dslt_pkg::CAPACITY_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dslt_pkg::t_in_item  i_item,
    input  logic                i_res_take,
    output logic                o_busy,
    output logic                o_done,
    output dslt_pkg::t_out_item o_result
);
    import dslt_pkg::*;

    `include "descending_sorted_list_table_top_assert.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];

    t_state             r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_match, n_match;
    logic signed [31:0] r_carry, n_carry;
    logic               r_flag, n_flag;
    logic [1:0]         r_status, n_status;
    logic signed [31:0] r_rdata;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;

    // Shared compare unit: the key against the entry just read.
    logic w_gt, w_eq;
    assign w_gt = r_key > r_rdata;
    assign w_eq = r_key == r_rdata;

    logic w_at_end, w_full;
    assign w_at_end = (r_idx == r_n);
    assign w_full   = (r_n == CW'(CAPACITY));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.operation == OP_CLEAR) begin
                        n_state = S_DONE;
                    end else if (i_item.operation == OP_INSERT && w_full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_op != OP_INSERT && w_at_end) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_op == OP_INSERT && w_at_end) begin
                    n_state = S_DONE;
                end else if (r_op == OP_SEARCH && w_gt) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table writes.
    always_comb begin
        n_op     = r_op;
        n_key    = r_key;
        n_n      = r_n;
        n_idx    = r_idx;
        n_match  = r_match;
        n_carry  = r_carry;
        n_flag   = r_flag;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_item.operation;
                    n_key    = i_item.value;
                    n_idx    = '0;
                    n_match  = '0;
                    n_flag   = 1'b0;
                    n_status = STS_OK;
                    if (i_item.operation == OP_CLEAR) begin
                        n_n = '0;
                    end else if (i_item.operation == OP_INSERT && w_full) begin
                        n_status = STS_FULL;
                    end
                end
            end
            S_READ: begin
                if (r_op == OP_DELETE && w_at_end) begin
                    if (r_flag) begin
                        n_n = r_n - 1'b1;
                    end else begin
                        n_status = STS_NOT_FOUND;
                    end
                end
            end
            S_EVAL: begin
                n_idx = r_idx + 1'b1;
                priority case (r_op)
                    OP_INSERT: begin
                        // Once the value is placed, each later entry moves down by one.
                        if (r_flag) begin
                            w_we    = 1'b1;
                            w_wdata = r_carry;
                            n_carry = r_rdata;
                        end else if (w_at_end || w_gt || w_eq) begin
                            w_we    = 1'b1;
                            w_wdata = r_key;
                            n_carry = r_rdata;
                            n_flag  = 1'b1;
                        end
                        if (w_at_end) begin
                            n_n = r_n + 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        if (w_eq) begin
                            n_match = r_match + 1'b1;
                        end
                    end
                    default: begin
                        // Delete: after the first match, each entry moves up by one.
                        if (r_flag) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_idx - 1'b1);
                            w_wdata = r_rdata;
                        end else if (w_eq) begin
                            n_flag = 1'b1;
                        end
                    end
                endcase
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_match  <= n_match;
        r_carry  <= n_carry;
        r_flag   <= n_flag;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_READ) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    logic [31:0] w_match_ext, w_n_ext;
    assign w_match_ext = 32'(r_match);
    assign w_n_ext     = 32'(r_n);

    assign o_busy               = (r_state != S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_result.status      = r_status;
    assign o_result.match_count = w_match_ext[4:0];
    assign o_result.entry_count = w_n_ext[4:0];

    `DSLT_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_n <= CW'(CAPACITY))
    `DSLT_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n,
        r_state == S_READ || r_state == S_EVAL, r_idx <= r_n)
    `DSLT_ASSERT_SAME(a_clear_empty, i_clk, i_rst_n,
        r_state == S_DONE && r_op == OP_CLEAR, r_n == '0)
    `DSLT_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n,
        r_state == S_DONE && !i_res_take, r_state == S_DONE && $stable(r_n))

endmodule

// ===== hdl/descending_sorted_list_table_top.sv =====
// Sequencing: clear and an insert into a full table go straight to the done state; any other
// operation reads, then compares, each visited entry, insert also visiting the free slot; a search
// stops at the first entry below the key, and search and delete otherwise run to the fill level.
// Flow: one transaction at a time; the next one is accepted in the cycle after the result register
// loads, which an output stall can hold off while an earlier result is still pending.
// Reset: synchronous, active low; the table is empty afterwards and no result is pending.
module descending_sorted_list_table_top #(
    parameter int CAPACITY = dslt_pkg::CAPACITY_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dslt_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dslt_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import dslt_pkg::*;

    logic      w_busy, w_done, w_take;
    t_out_item w_result;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign o_in_stall = w_busy;
    assign w_take     = w_done && (!r_out_valid || !i_out_stall);

    dslt_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !w_busy),
        .i_item     (i_in_item),
        .i_res_take (w_take),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== verif/descending_sorted_list_table_top_tb.sv =====
`timescale 1ns / 1ps

module descending_sorted_list_table_top_tb;
    import dslt_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall;

    // Shadow copy of the table contents, kept in descending order.
    logic signed [31:0] shadow_entries[$];
    t_out_item          pending_results[$];

    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    descending_sorted_list_table_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Applies one operation to the shadow table and returns the result it must produce.
    function automatic t_out_item predict_table_op(t_in_item item);
        t_out_item          res;
        logic signed [31:0] v;
        int                 i;
        int                 pos;
        int                 hits;
        v    = item.value;
        res  = '0;
        hits = 0;
        res.status = STS_OK;
        case (item.operation)
            OP_INSERT: begin
                if (shadow_entries.size() >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    pos = shadow_entries.size();
                    for (i = 0; i < shadow_entries.size(); i++) begin
                        if (v >= shadow_entries[i]) begin
                            pos = i;
                            break;
                        end
                    end
                    shadow_entries.insert(pos, v);
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < shadow_entries.size(); i++) begin
                    if (v > shadow_entries[i]) break;
                    if (v == shadow_entries[i]) hits++;
                end
            end
            OP_DELETE: begin
                res.status = STS_NOT_FOUND;
                for (i = 0; i < shadow_entries.size(); i++) begin
                    if (shadow_entries[i] == v) begin
                        shadow_entries.delete(i);
                        res.status = STS_OK;
                        break;
                    end
                end
            end
            default: begin
                shadow_entries.delete();
            end
        endcase
        res.match_count = 5'(hits);
        res.entry_count = 5'(shadow_entries.size());
        return res;
    endfunction

    function automatic void note_mismatch(string what, t_out_item want, t_out_item got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected status=%0d match_count=%0d entry_count=%0d, got status=%0d match_count=%0d entry_count=%0d",
                     $realtime, what, want.status, want.match_count, want.entry_count,
                     got.status, got.match_count, got.entry_count);
        end
    endfunction

    // Values lean toward a small range and current entries, so that repeats and hits are common.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return int'($urandom_range(0, 8)) - 4;
        if (sel < 65 && shadow_entries.size() != 0)
            return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
        if (sel < 80) begin
            case ($urandom_range(0, 5))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return VAL_MAX - 1;
                3: return VAL_MIN + 1;
                4: return 0;
                default: return -1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_operation(int ins_pct, int srch_pct, int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) return OP_INSERT;
        if (r < ins_pct + srch_pct) return OP_SEARCH;
        if (r < ins_pct + srch_pct + del_pct) return OP_DELETE;
        return OP_CLEAR;
    endfunction

    // Offers one transaction and records its expected result once it is taken.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] val);
        t_in_item item;
        int       gap;
        item.operation = op;
        item.value     = val;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_table_op(item));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(OP_SEARCH, 0);
        send_item(OP_DELETE, 0);
        send_item(OP_CLEAR, VAL_MAX);
    endtask

    task automatic test_duplicates_and_extremes();
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, -1);
        send_item(OP_SEARCH, 0);
        // A value above every entry but the first ends the scan early.
        send_item(OP_SEARCH, 5);
        send_item(OP_SEARCH, VAL_MIN);
        send_item(OP_DELETE, 0);
        send_item(OP_DELETE, 7);
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_entries.size() < CAPACITY)
            send_item(OP_INSERT, int'(shadow_entries.size() % 3) - 1);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_SEARCH, 0);
        send_item(OP_SEARCH, VAL_MIN);
        send_item(OP_CLEAR, 0);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int n;
        int ins_pct;
        int srch_pct;
        int del_pct;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            // Growing, balanced and shrinking mixes walk the fill level between empty
            // and full; the last mix hits clear often.
            case (phase % 4)
                0: begin ins_pct = 66; srch_pct = 20; del_pct = 12; end
                1: begin ins_pct = 40; srch_pct = 32; del_pct = 26; end
                2: begin ins_pct = 25; srch_pct = 25; del_pct = 48; end
                default: begin ins_pct = 25; srch_pct = 25; del_pct = 25; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_operation(ins_pct, srch_pct, del_pct), pick_value());
            if (phase == RANDOM_PHASES / 2) wait_for_results();
        end
    endtask

    initial begin : result_receiver
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with no transaction pending", '0, o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.match_count !== want.match_count ||
                    o_out_item.entry_count !== want.entry_count) begin
                    note_mismatch("result fields differ", want, o_out_item);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_duplicates_and_extremes();
        test_fill_to_capacity();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
